// ===== rtl/core/keyboard_key_state_tracker_core_defines.svh =====
// Assertion macros shared by the key state tracker core.
// Stand-alone header; no other file is needed.
`ifndef KEYBOARD_KEY_STATE_TRACKER_CORE_DEFINES_SVH
`define KEYBOARD_KEY_STATE_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KST_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("key state tracker: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define KST_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("key state tracker: next-cycle check failed");

`endif

// ===== rtl/core/kst_pkg.sv =====
// Types and constants of the key state tracker core.
// No dependencies; used by the controller, the datapath and the top level.
package kst_pkg;

    // Request operations
    localparam logic [1:0] OP_KEY_EVENT   = 2'd0;
    localparam logic [1:0] OP_AUTO_CHECK  = 2'd1;
    localparam logic [1:0] OP_CLR_PENDING = 2'd2;

    // Source codes on the request
    localparam logic [1:0] SRC_CODE_INVALID = 2'd3;

    // Source mask bits
    localparam logic [2:0] SRC_MASK_HW   = 3'b001;
    localparam logic [2:0] SRC_MASK_VIRT = 3'b010;
    localparam logic [2:0] SRC_MASK_AUTO = 3'b100;

    // Key roles
    localparam logic [3:0] ROLE_MOD_FIRST  = 4'd1;
    localparam logic [3:0] ROLE_MOD_LAST   = 4'd9;
    localparam logic [3:0] ROLE_LOCK_FIRST = 4'd10;
    localparam logic [3:0] ROLE_LOCK_LAST  = 4'd12;

    // Result kinds
    localparam logic KIND_DOWN = 1'b0;
    localparam logic KIND_UP   = 1'b1;

    // Configuration register indexes
    localparam logic CFG_KEYDOWN_EN = 1'b0;
    localparam logic CFG_KEYUP_EN   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } kst_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic commit;
    } kst_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic emit;
        logic out_full;
    } kst_status_t;

endpackage

// ===== rtl/core/kst_ctrl.sv =====
// Controller of the key state tracker: clearing sweep, accept and commit sequencing.
// Depends on kst_pkg.
module kst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_stall,
    input  kst_pkg::kst_status_t status,
    output logic                 in_stall,
    output kst_pkg::kst_cmd_t    cmd
);
    import kst_pkg::*;

    kst_state_t state_reg;
    kst_state_t state_next;
    logic       blocked;

    // A result that cannot enter the output register holds the commit
    assign blocked = status.emit && status.out_full && out_stall;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall       = 1'b1;
        cmd.accept     = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = !blocked;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/kst_datapath.sv =====
// Datapath of the key state tracker: key entry memory, modifier word and result register.
// Depends on kst_pkg and keyboard_key_state_tracker_core_defines.svh.
`include "keyboard_key_state_tracker_core_defines.svh"

module kst_datapath #(
    parameter int NUM_KEYS = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kst_pkg::kst_cmd_t    cmd,
    output kst_pkg::kst_status_t status,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic                 cfg_data,
    input  logic [1:0]           op,
    input  logic [1:0]           source,
    input  logic                 pressed,
    input  logic [8:0]           scancode,
    input  logic [3:0]           key_role,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 event_kind,
    output logic                 repeat_res,
    output logic [8:0]           key_number,
    output logic [11:0]          modifiers
);
    import kst_pkg::*;

    localparam int AW = $clog2(NUM_KEYS);
    localparam int CW = (AW > 9) ? AW : 9;

    // Key entry memory: source mask per key, held is a non-zero mask
    logic [2:0]    mask_mem [NUM_KEYS];
    logic [2:0]    rd_mask_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    // Latched request
    logic [1:0]    op_reg;
    logic [1:0]    src_reg;
    logic          press_reg;
    logic [8:0]    code_reg;
    logic [3:0]    role_reg;
    logic          code_ok_reg;
    logic [AW-1:0] addr_reg;

    // Architectural state
    logic          kd_en_reg;
    logic          ku_en_reg;
    logic [11:0]   mod_word_reg;
    logic [11:0]   mod_word_next;
    logic          pending_reg;
    logic          pending_next;

    // Result register
    logic          out_valid_reg;
    logic          kind_reg;
    logic          rep_reg;
    logic [8:0]    keynum_reg;
    logic [11:0]   mods_reg;

    // Event evaluation
    logic [CW:0]   code_w;
    logic          code_ok;
    logic          held;
    logic          ev_active;
    logic [2:0]    ev_src;
    logic          ev_press;
    logic          ev_taken;
    logic          ev_rep;
    logic [2:0]    mask_next;
    logic [11:0]   modbit;
    logic [11:0]   lockbit;
    logic          emit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [2:0]    mem_wdata;

    // Range check of the incoming scancode
    assign code_w  = (CW + 1)'(scancode);
    assign code_ok = (code_w != '0) && (code_w < (CW + 1)'(NUM_KEYS));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kd_en_reg <= 1'b1;
            ku_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEYDOWN_EN: kd_en_reg <= cfg_data;
                CFG_KEYUP_EN:   ku_en_reg <= cfg_data;
                default:        kd_en_reg <= kd_en_reg;
            endcase
        end
    end

    // Capture request fields
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= op;
            src_reg     <= source;
            press_reg   <= pressed;
            code_reg    <= scancode;
            role_reg    <= key_role;
            code_ok_reg <= code_ok;
            addr_reg    <= code_w[AW-1:0];
        end
    end

    // Evaluate the event against the stored entry
    always_comb
    begin
        held      = (rd_mask_reg != 3'b000);
        ev_active = 1'b0;
        ev_src    = SRC_MASK_AUTO;
        ev_press  = 1'b0;
        case (op_reg)
            OP_KEY_EVENT:
            begin
                ev_active = code_ok_reg && (src_reg != SRC_CODE_INVALID);
                ev_src    = 3'(3'b001 << src_reg);
                ev_press  = press_reg;
            end
            OP_AUTO_CHECK:
            begin
                ev_active = code_ok_reg && pending_reg && (rd_mask_reg == SRC_MASK_AUTO);
            end
            default:
            begin
                ev_active = 1'b0;
            end
        endcase

        ev_taken  = 1'b0;
        ev_rep    = 1'b0;
        mask_next = rd_mask_reg;
        if (ev_press)
        begin
            mask_next = rd_mask_reg | ev_src;
            ev_taken  = !(held && ((rd_mask_reg & ev_src) == 3'b000));
            ev_rep    = held;
        end
        else if (held)
        begin
            mask_next = 3'b000;
            ev_taken  = 1'b1;
        end
        ev_taken = ev_taken && ev_active;
    end

    // Modifier and lock bit for the role
    always_comb
    begin
        modbit  = 12'd0;
        lockbit = 12'd0;
        if (role_reg inside {[ROLE_MOD_FIRST:ROLE_MOD_LAST]})
        begin
            modbit = 12'(12'd1 << (role_reg - ROLE_MOD_FIRST));
        end
        if (role_reg inside {[ROLE_LOCK_FIRST:ROLE_LOCK_LAST]})
        begin
            lockbit = 12'(12'd1 << (role_reg - ROLE_MOD_FIRST));
        end
    end

    // Update modifier word and pending flag
    always_comb
    begin
        mod_word_next = mod_word_reg;
        pending_next  = pending_reg;
        if (ev_taken)
        begin
            if (ev_press)
            begin
                mod_word_next = (mod_word_reg ^ lockbit) | modbit;
            end
            else
            begin
                mod_word_next = mod_word_reg & ~modbit;
            end
            if (ev_src == SRC_MASK_AUTO)
            begin
                pending_next = 1'b1;
            end
        end
        if (op_reg == OP_CLR_PENDING)
        begin
            pending_next = 1'b0;
        end
    end

    assign emit = ev_taken && (ev_press ? kd_en_reg : ku_en_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_word_reg <= 12'd0;
            pending_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            mod_word_reg <= mod_word_next;
            pending_reg  <= pending_next;
        end
    end

    // Clearing sweep counter
    assign clr_cnt_next = clr_cnt_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Memory write port: sweep or write-back
    assign mem_we    = cmd.clear_step || (cmd.commit && ev_active);
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : addr_reg;
    assign mem_wdata = cmd.clear_step ? 3'b000 : mask_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mask_mem[mem_waddr] <= mem_wdata;
        end
    end

    // Memory read port, registered
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_mask_reg <= mask_mem[code_w[AW-1:0]];
        end
    end

    // Result register: drop on take, load on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            kind_reg   <= ev_press ? KIND_DOWN : KIND_UP;
            rep_reg    <= ev_press && ev_rep;
            keynum_reg <= code_reg;
            mods_reg   <= mod_word_next;
        end
    end

    assign status.clear_last = (clr_cnt_reg == AW'(NUM_KEYS - 1));
    assign status.emit       = emit;
    assign status.out_full   = out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign repeat_res = rep_reg;
    assign key_number = keynum_reg;
    assign modifiers  = mods_reg;

    // Checks
    `KST_ASSERT_IMP(a_no_commit_in_sweep, clk, rst_n, cmd.clear_step, !cmd.commit && !cmd.accept)
    `KST_ASSERT_IMP(a_up_no_repeat, clk, rst_n, out_valid_reg && (kind_reg == KIND_UP), !rep_reg)
    `KST_ASSERT_IMP(a_key_nonzero, clk, rst_n, out_valid_reg, keynum_reg != 9'd0)
    `KST_ASSERT_NXT(a_pending_cleared, clk, rst_n, cmd.commit && (op_reg == OP_CLR_PENDING), !pending_reg)

endmodule

// ===== rtl/core/keyboard_key_state_tracker_core.sv =====
// Each request is accepted in ST_IDLE, which reads the key entry from the key memory, and
// committed in ST_EXEC, which writes it back and loads the result register; the commit is
// held while a result cannot enter a full, stalled output register. No new request is taken
// before the last one commits, because of that read-modify-write of the key memory.
// After reset the key memory is swept to zero, one entry a cycle, over all NUM_KEYS entries;
// in_stall stays high meanwhile. Configuration writes are taken at any time.
module keyboard_key_state_tracker_core #(
    parameter int NUM_KEYS = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [1:0]  source,
    input  logic        pressed,
    input  logic [8:0]  scancode,
    input  logic [3:0]  key_role,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        event_kind,
    output logic        repeat_res,
    output logic [8:0]  key_number,
    output logic [11:0] modifiers
);
    import kst_pkg::*;

    kst_cmd_t    cmd;
    kst_status_t status;

    // Sequencing
    kst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    // Key state and results
    kst_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .source     (source),
        .pressed    (pressed),
        .scancode   (scancode),
        .key_role   (key_role),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .repeat_res (repeat_res),
        .key_number (key_number),
        .modifiers  (modifiers)
    );

endmodule
